@@ design/cpc_pkg.sv @@
// Shared types, constants and helpers for the cascaded position checksum block.
package cpc_pkg;

  localparam int CPC_MAX_CHECK_LEN = 15;
  localparam int CPC_BYTE_W        = 8;
  localparam int CPC_CFG_W         = 4;
  localparam int CPC_USER_W        = 4;

  localparam logic [CPC_CFG_W-1:0] CPC_CHECK_LEN_RST = 4'd1;

  localparam logic MODE_GEN    = 1'b0;
  localparam logic MODE_VERIFY = 1'b1;

  localparam int USER_IS_CHECK  = 0;
  localparam int USER_IS_VERDIT = 1;
  localparam int USER_CHECK_OK  = 2;
  localparam int USER_TOO_SHORT = 3;

  localparam logic [CPC_BYTE_W-1:0] SUM_ZERO = 8'h00;
  localparam logic [CPC_BYTE_W-1:0] SUM_ONES = 8'hFF;
  localparam logic [CPC_BYTE_W-1:0] SUM_SUBST = 8'h01;

  typedef enum logic {
    ST_RUN,
    ST_GEN
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic gen_step;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic eff_zero;
    logic gen_last;
  } stat_t;

  function automatic logic [CPC_BYTE_W-1:0] fix_check(input logic [CPC_BYTE_W-1:0] s);
    if (s == SUM_ZERO || s == SUM_ONES) begin
      return SUM_SUBST;
    end
    return s;
  endfunction

endpackage

@@ design/cascaded_position_checksum_core.sv @@
// Top level of the cascaded position checksum block: controller plus datapath.
//
// Input stream (in_*): one buffer byte per transaction; in_tlast marks the
// last data byte (generate) or last byte of the whole buffer (verify);
// in_tuser is the mode, 0 generate, 1 verify, sampled on every byte.
// Output stream (out_*): echoed data bytes, generated check bytes, or one
// verify verdict per buffer; out_tlast marks the last result of a buffer.
// Configuration: cfg_we writes cfg_wdata into check_len (reset value 1);
// write only while the block is idle.
// A result appears in the output register in the cycle after its transaction.
// The block takes one byte per cycle while the receiver keeps up, limited by the
// single output register; after a generate-mode last byte the controller emits
// check_len check bytes from the running-sum loop, with in_tready low. A verify
// buffer yields no output until its last byte.
// Reset clears the running sum, position, history and count and empties the
// output register. When the receiver stalls, the output register holds and
// in_tready drops until the result is taken.
module cascaded_position_checksum_core
  import cpc_pkg::*;
#(
  parameter int MAX_CHECK_LEN = CPC_MAX_CHECK_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CPC_CFG_W-1:0]  cfg_wdata,   // check_len
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CPC_BYTE_W-1:0] in_tdata,    // data_byte
  input  logic                  in_tlast,
  input  logic                  in_tuser,    // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CPC_BYTE_W-1:0] out_tdata,   // out_byte
  output logic [CPC_USER_W-1:0] out_tuser,   // is_check_byte, is_verdict, check_ok, too_short
  output logic                  out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  cpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpc_datapath #(
    .MAX_CHECK_LEN (MAX_CHECK_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .in_eob     (in_tlast),
    .in_mode    (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  a_no_take_while_gen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gen_step |-> !in_tready)
    else $error("input accepted while emitting check bytes");

  a_last_gen_closes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gen_step && stat.gen_last |=> out_tvalid && out_tlast && out_tuser[USER_IS_CHECK])
    else $error("final check byte not marked last");

  a_verdict_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_IS_VERDIT] |-> out_tlast && !out_tuser[USER_IS_CHECK])
    else $error("verdict not marked last or marked as check byte");

  a_short_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_TOO_SHORT] |-> !out_tuser[USER_CHECK_OK])
    else $error("short buffer reported as passing");
`endif

endmodule

@@ design/cpc_ctrl.sv @@
// Controller: sequences byte intake and the emission of trailing check bytes.
module cpc_ctrl
  import cpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  in_tlast,
  input  logic  in_mode,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.gen_step  = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready     = stat.slot_free;
        cmd.take_byte = in_tvalid && stat.slot_free;
        if (cmd.take_byte && in_tlast && in_mode == MODE_GEN && !stat.eff_zero) begin
          state_nxt = ST_GEN;
        end
      end
      ST_GEN: begin
        cmd.gen_step = stat.slot_free;
        if (stat.slot_free && stat.gen_last) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule

@@ design/cpc_datapath.sv @@
// Datapath: running sum, position, match history, config register and output register.
module cpc_datapath
  import cpc_pkg::*;
#(
  parameter int MAX_CHECK_LEN = CPC_MAX_CHECK_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CPC_CFG_W-1:0]  cfg_wdata,
  input  logic [CPC_BYTE_W-1:0] in_byte,
  input  logic                  in_eob,
  input  logic                  in_mode,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CPC_BYTE_W-1:0] out_tdata,
  output logic [CPC_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  localparam int SW = $clog2(MAX_CHECK_LEN + 1);

  logic [CPC_CFG_W-1:0]     check_len_r;
  logic [CPC_BYTE_W-1:0]    sum_r, sum_nxt;
  logic [CPC_BYTE_W-1:0]    pos_r, pos_nxt;
  logic [MAX_CHECK_LEN-1:0] hist_r, hist_nxt;
  logic [SW-1:0]            seen_r, seen_nxt;
  logic [CPC_CFG_W-1:0]     remain_r, remain_nxt;
  logic                     clear;

  logic                     ovalid_r, ovalid_nxt;
  logic [CPC_BYTE_W-1:0]    obyte_r, obyte_nxt;
  logic [CPC_USER_W-1:0]    ouser_r, ouser_nxt;
  logic                     olast_r, olast_nxt;

  logic [CPC_CFG_W-1:0]     eff;
  logic [CPC_BYTE_W-1:0]    expect_byte;
  logic [CPC_BYTE_W-1:0]    absorb_byte;
  logic [MAX_CHECK_LEN-1:0] need;
  logic                     short_f;
  logic                     ok_f;

  always_comb begin
    eff = check_len_r;
    if (int'(check_len_r) > MAX_CHECK_LEN) begin
      eff = CPC_CFG_W'(MAX_CHECK_LEN);
    end
    for (int i = 0; i < MAX_CHECK_LEN; i++) begin
      need[i] = i < int'(eff);
    end
  end

  assign expect_byte = fix_check(sum_r);
  assign absorb_byte = cmd.gen_step ? expect_byte : in_byte;

  assign stat.slot_free = !ovalid_r || out_tready;
  assign stat.eff_zero  = eff == '0;
  assign stat.gen_last  = remain_r == CPC_CFG_W'(1);

  always_comb begin
    sum_nxt    = sum_r;
    pos_nxt    = pos_r;
    hist_nxt   = hist_r;
    seen_nxt   = seen_r;
    remain_nxt = remain_r;
    clear      = 1'b0;
    short_f    = 1'b0;
    ok_f       = 1'b0;
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;

    if (cmd.take_byte) begin
      hist_nxt = MAX_CHECK_LEN'({hist_r, in_byte == expect_byte});
    end
    if (cmd.take_byte || cmd.gen_step) begin
      sum_nxt = sum_r + (absorb_byte ^ pos_r);
      pos_nxt = pos_r + CPC_BYTE_W'(1);
      if (int'(seen_r) < MAX_CHECK_LEN) begin
        seen_nxt = seen_r + SW'(1);
      end
    end
    short_f = int'(seen_r) + 1 < int'(eff) && int'(seen_r) < MAX_CHECK_LEN;
    if (int'(seen_r) >= MAX_CHECK_LEN) begin
      short_f = int'(seen_r) < int'(eff);
    end
    ok_f = !short_f && ((hist_nxt & need) == need);

    if (cmd.take_byte) begin
      if (in_mode == MODE_GEN) begin
        ovalid_nxt = 1'b1;
        obyte_nxt  = in_byte;
        ouser_nxt  = '0;
        olast_nxt  = in_eob && stat.eff_zero;
        if (in_eob) begin
          remain_nxt = eff;
          clear      = stat.eff_zero;
        end
      end else if (in_eob) begin
        ovalid_nxt                 = 1'b1;
        obyte_nxt                  = '0;
        ouser_nxt                  = '0;
        ouser_nxt[USER_IS_VERDIT]  = 1'b1;
        ouser_nxt[USER_CHECK_OK]   = ok_f;
        ouser_nxt[USER_TOO_SHORT]  = short_f;
        olast_nxt                  = 1'b1;
        clear                      = 1'b1;
      end
    end

    if (cmd.gen_step) begin
      ovalid_nxt                = 1'b1;
      obyte_nxt                 = expect_byte;
      ouser_nxt                 = '0;
      ouser_nxt[USER_IS_CHECK]  = 1'b1;
      olast_nxt                 = stat.gen_last;
      remain_nxt                = remain_r - CPC_CFG_W'(1);
      clear                     = stat.gen_last;
    end

    if (clear) begin
      sum_nxt  = '0;
      pos_nxt  = '0;
      hist_nxt = '0;
      seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_len_r <= CPC_CHECK_LEN_RST;
      sum_r       <= '0;
      pos_r       <= '0;
      hist_r      <= '0;
      seen_r      <= '0;
      remain_r    <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        check_len_r <= cfg_wdata;
      end
      sum_r    <= sum_nxt;
      pos_r    <= pos_nxt;
      hist_r   <= hist_nxt;
      seen_r   <= seen_nxt;
      remain_r <= remain_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule
